// ===== rtl/core/tlet_pkg.sv =====
// Package of the timed LED event table: field widths, function and result codes,
// the slot entry layout and the command and status structs between the controller
// and the datapath. It depends on nothing.
`default_nettype none

package tlet_pkg;

   // Fixed field widths of the stream words.
   localparam int TIME_W      = 32;
   localparam int LED_SEL_W   = 3;
   localparam int COLOR_W     = 2;
   localparam int SLOT_SEL_W  = 3;
   localparam int LED_COLOR_W = 3;
   localparam int FUNC_W      = 2;
   localparam int KIND_W      = 2;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 16;

   // Width used to compare a 3-bit index against a count of up to 64.
   localparam int IDX_EXT_W   = 7;

   localparam logic [LED_COLOR_W-1:0] COLOR_BLACK = 3'd0;

   // Function codes of an input word.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_ADD    = 2'd1,
      FUNC_REMOVE = 2'd2
   } func_type;

   // Kind codes of a result word.
   typedef enum logic [KIND_W-1:0] {
      KIND_LED    = 2'd0,
      KIND_ADD    = 2'd1,
      KIND_REMOVE = 2'd2
   } kind_type;

   // One stored event.
   typedef struct packed {
      logic                   turn_on;
      logic [LED_SEL_W-1:0]   led;
      logic [COLOR_W-1:0]     color;
      logic [TIME_W-1:0]      due;
   } slot_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic idx_clear;
      logic idx_step;
      logic scan_read;
      logic scan_eval;
      logic led_read;
      logic emit_load;
      logic add_exec;
      logic rem_read;
      logic rem_exec;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      func_type in_func;
      logic     scan_done;
      logic     emit_done;
      logic     out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/timed_led_event_table.sv =====
// Timed LED event table, top level.
// The req channel carries one word per operation: tuser selects tick, add or
// remove. An add stores an event in the lowest free slot and answers with one add
// status word (slot or table full). A remove frees the named slot, turns its LED
// black and answers with one remove status word. A tick scans all slots in order;
// each valid slot whose due time is not after the tick's time sets its LED (black
// for an off event) and is freed, later slots winning. The tick then returns one
// color word per LED, the last one marked by tlast. Unknown functions are taken
// and produce nothing.
// Timing: the controller handles one word at a time. The length of a tick is set
// by the one-read-per-cycle ports of the slot and LED stores, since each slot and
// each LED is read in a read state of its own before it is evaluated or emitted.
// An add loads its result word in the add state, a remove after its slot read,
// and a tick its first color word after the scan of all slots; the color words
// of a tick then follow, each after its own LED read.
// The result register lets the next req word be taken while a result waits.
// When the receiver stalls, the current operation holds at its next result.
// Reset frees all slots and turns all LEDs black at once; no clearing pass.
// Depends on tlet_pkg, tlet_ctrl, tlet_dp and tlet_ram.
`default_nettype none

module timed_led_event_table #(
   parameter int SLOTS     = 7,
   parameter int LED_COUNT = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // req_tdata: now_time[31:0], due_time[63:32], turn_on[64], led_select[67:65],
   //            color_code[69:68], slot_select[72:70], zero[79:73]
   input  wire logic [tlet_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: func[1:0]
   input  wire logic [tlet_pkg::FUNC_W-1:0]      req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // rsp_tdata: led_index[2:0], led_color[5:3], slot_used[8:6], table_full[9],
   //            zero[15:10]
   output logic      [tlet_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: kind[1:0]
   output logic      [tlet_pkg::KIND_W-1:0]      rsp_tuser,
   output logic                                  rsp_tlast
);

   import tlet_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   tlet_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tlet_dp #(
      .SLOTS     (SLOTS),
      .LED_COUNT (LED_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   localparam logic [IDX_EXT_W-1:0] LastLedExt = IDX_EXT_W'(LED_COUNT - 1);

   // A tick keeps the input closed for its scan.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == FUNC_TICK) |=> !req_tready)
      else $error("input taken during a tick scan");

   // A result is only loaded when the result register is free.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load || cmd.add_exec || cmd.rem_exec) |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");

   // The marked color word is the one for the last LED.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast && rsp_tuser == KIND_LED)
      |-> (rsp_tdata[2:0] == LastLedExt[2:0]))
      else $error("last color word is not the last LED");

   // A result loads in the cycle after the command and shows as valid.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load || cmd.add_exec || cmd.rem_exec) |=> rsp_tvalid)
      else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tlet_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the slot store and the LED color store; depends on nothing.
`default_nettype none

module tlet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds when not read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tlet_ctrl.sv =====
// Controller of the timed LED event table: the state machine that sequences ticks,
// adds and removes and drives the datapath by commands. Depends on tlet_pkg.
`default_nettype none

module tlet_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire tlet_pkg::ctrl_status_type status,
   output tlet_pkg::ctrl_cmd_type         cmd
);

   import tlet_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_SCAN_RD  = 8'b0000_0010,
      ST_SCAN_EV  = 8'b0000_0100,
      ST_EMIT_RD  = 8'b0000_1000,
      ST_EMIT_OUT = 8'b0001_0000,
      ST_ADD      = 8'b0010_0000,
      ST_REM_RD   = 8'b0100_0000,
      ST_REM_WR   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Items are taken only between operations.
   assign req_tready = (state_ff == ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               case (status.in_func)
                  FUNC_TICK: begin
                     cmd.idx_clear = 1'b1;
                     state_in      = ST_SCAN_RD;
                  end
                  FUNC_ADD: begin
                     state_in = ST_ADD;
                  end
                  FUNC_REMOVE: begin
                     state_in = ST_REM_RD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in      = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            cmd.scan_eval = 1'b1;
            if (status.scan_done) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_EMIT_RD;
            end else begin
               cmd.idx_step = 1'b1;
               state_in     = ST_SCAN_RD;
            end
         end
         ST_EMIT_RD: begin
            cmd.led_read = 1'b1;
            state_in     = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (status.emit_done) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.idx_step = 1'b1;
                  state_in     = ST_EMIT_RD;
               end
            end
         end
         ST_ADD: begin
            if (status.out_free) begin
               cmd.add_exec = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_REM_RD: begin
            cmd.rem_read = 1'b1;
            state_in     = ST_REM_WR;
         end
         ST_REM_WR: begin
            if (status.out_free) begin
               cmd.rem_exec = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/tlet_dp.sv =====
// Datapath of the timed LED event table: item registers, slot and LED stores with
// their valid bits, the scan counter and the result register. Depends on tlet_pkg
// and tlet_ram.
`default_nettype none

module tlet_dp #(
   parameter int SLOTS     = 7,
   parameter int LED_COUNT = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tlet_pkg::ctrl_cmd_type              cmd,
   output tlet_pkg::ctrl_status_type                status,
   input  wire logic [tlet_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic [tlet_pkg::FUNC_W-1:0]         req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [tlet_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic      [tlet_pkg::KIND_W-1:0]         rsp_tuser,
   output logic                                     rsp_tlast
);

   import tlet_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LED_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int CNT_W  = (SLOT_W > LED_W) ? SLOT_W : LED_W;
   localparam int ENTRY_W = $bits(slot_entry_type);

   // Captured item fields.
   logic [TIME_W-1:0]     now_ff;
   logic [TIME_W-1:0]     due_ff;
   logic                  on_ff;
   logic [LED_SEL_W-1:0]  led_ff;
   logic [COLOR_W-1:0]    color_ff;
   logic [SLOT_SEL_W-1:0] slot_ff;

   // Control state.
   logic [CNT_W-1:0]     idx_ff;
   logic [CNT_W-1:0]     idx_in;
   logic [SLOTS-1:0]     slot_valid_ff;
   logic [SLOTS-1:0]     slot_valid_in;
   logic [SLOTS-1:0]     slot_written_ff;
   logic [SLOTS-1:0]     slot_written_in;
   logic [LED_COUNT-1:0] led_written_ff;
   logic [LED_COUNT-1:0] led_written_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;

   // Result register.
   kind_type               rsp_kind_ff;
   logic [2:0]             rsp_index_ff;
   logic [LED_COLOR_W-1:0] rsp_color_ff;
   logic [2:0]             rsp_slot_ff;
   logic                   rsp_full_ff;
   logic                   rsp_last_ff;

   logic [SLOT_W-1:0]     idx_slot;
   logic [LED_W-1:0]      idx_led;
   logic [IDX_EXT_W-1:0]  idx_ext;
   logic [IDX_EXT_W-1:0]  rem_ext;
   logic [SLOT_W-1:0]     rem_slot;
   logic                  rem_in_range;
   logic [SLOT_W-1:0]     ev_slot;
   logic [ENTRY_W-1:0]    slot_q;
   logic                  slot_rd_en;
   logic [SLOT_W-1:0]     slot_rd_addr;
   slot_entry_type        entry;
   slot_entry_type        new_entry;
   logic [IDX_EXT_W-1:0]  led_ext;
   logic [LED_W-1:0]      led_addr;
   logic                  led_in_range;
   logic                  hit;
   logic                  led_wr_en;
   logic [LED_COLOR_W-1:0] led_wr_data;
   logic [LED_COLOR_W-1:0] led_q;
   logic                  free_found;
   logic [SLOT_W-1:0]     free_slot;
   logic [IDX_EXT_W-1:0]  free_ext;
   logic                  out_free;

   assign idx_slot = idx_ff[SLOT_W-1:0];
   assign idx_led  = idx_ff[LED_W-1:0];
   assign idx_ext  = IDX_EXT_W'(idx_ff);

   // Remove target and its range check.
   assign rem_ext      = IDX_EXT_W'(slot_ff);
   assign rem_slot     = rem_ext[SLOT_W-1:0];
   assign rem_in_range = (rem_ext < IDX_EXT_W'(SLOTS));

   // Status to the controller.
   assign out_free         = !rsp_valid_ff || rsp_tready;
   assign status.in_func   = func_type'(req_tuser);
   assign status.scan_done = (idx_ff == CNT_W'(SLOTS - 1));
   assign status.emit_done = (idx_ff == CNT_W'(LED_COUNT - 1));
   assign status.out_free  = out_free;

   // Slot store read: the scan walks the counter, a remove reads its slot.
   assign slot_rd_en   = cmd.scan_read || (cmd.rem_read && rem_in_range);
   assign slot_rd_addr = cmd.rem_read ? rem_slot : idx_slot;

   // A slot that was never written reads as all zero.
   assign ev_slot = cmd.rem_exec ? rem_slot : idx_slot;
   assign entry   = (slot_written_ff[ev_slot]) ? slot_entry_type'(slot_q) : '0;

   assign led_ext      = IDX_EXT_W'(entry.led);
   assign led_addr     = led_ext[LED_W-1:0];
   assign led_in_range = (led_ext < IDX_EXT_W'(LED_COUNT));

   // A valid slot whose due time has come fires during the scan.
   assign hit = cmd.scan_eval && slot_valid_ff[idx_slot] && (now_ff >= entry.due);

   // An on event stores its color; an off event is handled by the written bit.
   assign led_wr_en   = hit && led_in_range && entry.turn_on;
   assign led_wr_data = LED_COLOR_W'(entry.color) + LED_COLOR_W'(1);

   assign new_entry.turn_on = on_ff;
   assign new_entry.led     = led_ff;
   assign new_entry.color   = color_ff;
   assign new_entry.due     = due_ff;

   // Lowest free slot for an add.
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end
   assign free_ext = IDX_EXT_W'(free_slot);

   tlet_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.add_exec && free_found),
      .wr_addr (free_slot),
      .wr_data (ENTRY_W'(new_entry)),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_q)
   );

   tlet_ram #(
      .WIDTH (LED_COLOR_W),
      .DEPTH (LED_COUNT)
   ) u_led_ram (
      .clock   (clock),
      .wr_en   (led_wr_en),
      .wr_addr (led_addr),
      .wr_data (led_wr_data),
      .rd_en   (cmd.led_read),
      .rd_addr (idx_led),
      .rd_data (led_q)
   );

   // Next values of the counter, valid bits and result valid.
   always_comb begin
      idx_in          = idx_ff;
      slot_valid_in   = slot_valid_ff;
      slot_written_in = slot_written_ff;
      led_written_in  = led_written_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (hit) begin
         slot_valid_in[idx_slot] = 1'b0;
         if (led_in_range) begin
            led_written_in[led_addr] = entry.turn_on;
         end
      end
      if (cmd.rem_exec && rem_in_range) begin
         slot_valid_in[rem_slot] = 1'b0;
         if (led_in_range) begin
            led_written_in[led_addr] = 1'b0;
         end
      end
      if (cmd.add_exec && free_found) begin
         slot_valid_in[free_slot]   = 1'b1;
         slot_written_in[free_slot] = 1'b1;
      end
      if (cmd.emit_load || cmd.add_exec || cmd.rem_exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff          <= '0;
         slot_valid_ff   <= '0;
         slot_written_ff <= '0;
         led_written_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         idx_ff          <= idx_in;
         slot_valid_ff   <= slot_valid_in;
         slot_written_ff <= slot_written_in;
         led_written_ff  <= led_written_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         now_ff   <= req_tdata[31:0];
         due_ff   <= req_tdata[63:32];
         on_ff    <= req_tdata[64];
         led_ff   <= req_tdata[67:65];
         color_ff <= req_tdata[69:68];
         slot_ff  <= req_tdata[72:70];
      end
   end

   // Result register loads.
   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_kind_ff  <= KIND_LED;
         rsp_index_ff <= idx_ext[2:0];
         rsp_color_ff <= led_written_ff[idx_led] ? led_q : COLOR_BLACK;
         rsp_slot_ff  <= 3'd0;
         rsp_full_ff  <= 1'b0;
         rsp_last_ff  <= status.emit_done;
      end else if (cmd.add_exec) begin
         rsp_kind_ff  <= KIND_ADD;
         rsp_index_ff <= 3'd0;
         rsp_color_ff <= COLOR_BLACK;
         rsp_slot_ff  <= free_found ? free_ext[2:0] : 3'd0;
         rsp_full_ff  <= !free_found;
         rsp_last_ff  <= 1'b1;
      end else if (cmd.rem_exec) begin
         rsp_kind_ff  <= KIND_REMOVE;
         rsp_index_ff <= 3'd0;
         rsp_color_ff <= COLOR_BLACK;
         rsp_slot_ff  <= slot_ff;
         rsp_full_ff  <= 1'b0;
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_full_ff, rsp_slot_ff, rsp_color_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== sim/timed_led_event_table_tb.sv =====
// Self-checking testbench of the timed LED event table: a directed table of
// words followed by random tick, add, remove and unused-function traffic, checked
// word by word. Depends on tlet_pkg and the timed_led_event_table RTL.
`default_nettype none

module timed_led_event_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tlet_pkg::*;

   localparam int SLOTS        = 7;
   localparam int LED_COUNT    = 8;
   localparam int ITEMS        = 400;
   localparam int LIMIT_NS     = 5_000_000;
   localparam int DRAIN_CYCLES = 2*SLOTS + 2*LED_COUNT + 10;
   localparam int REQ_USED_W   = 73;

   // Function code that the block takes and ignores.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // How the expectation of a directed row is formed.
   typedef enum logic [1:0] {
      CHECK_PREDICTED,
      CHECK_BLANK_TICK,
      CHECK_SILENT,
      CHECK_STATUS
   } check_mode_type;

   typedef struct packed {
      logic [FUNC_W-1:0]     func;
      logic [TIME_W-1:0]     now_t;
      logic [TIME_W-1:0]     due_t;
      logic                  turn_on;
      logic [LED_SEL_W-1:0]  led;
      logic [COLOR_W-1:0]    color;
      logic [SLOT_SEL_W-1:0] slot;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      logic [LED_SEL_W-1:0]   led_index;
      logic [LED_COLOR_W-1:0] led_color;
      logic [SLOT_SEL_W-1:0]  slot_used;
      logic                   table_full;
      logic                   last_word;
   } rsp_word_type;

   typedef struct packed {
      req_item_type   item;
      check_mode_type mode;
      rsp_word_type   typed;
   } dir_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   wire                    req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]      req_tuser  = '0;
   wire                    rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   wire  [RSP_TDATA_W-1:0] rsp_tdata;
   wire  [KIND_W-1:0]      rsp_tuser;
   wire                    rsp_tlast;

   // Shadow copy of the event table and the LED strip.
   logic                   shadow_valid [SLOTS];
   logic                   shadow_on    [SLOTS];
   logic [LED_SEL_W-1:0]   shadow_led   [SLOTS];
   logic [COLOR_W-1:0]     shadow_color [SLOTS];
   logic [TIME_W-1:0]      shadow_due   [SLOTS];
   logic [LED_COLOR_W-1:0] shadow_strip [LED_COUNT];

   rsp_word_type step_words[$];
   rsp_word_type pending_words[$];
   dir_row_type  directed[$];
   rsp_word_type got_word;
   rsp_word_type want_word;
   int          tx_idle_pct = 11;
   int          rx_idle_pct = 75;
   int          errors      = 0;
   int          checked     = 0;
   int          items_sent  = 0;
   int          ticks_sent  = 0;
   int          full_seen   = 0;
   int unsigned wall_now;

   timed_led_event_table #(
      .SLOTS     (SLOTS),
      .LED_COUNT (LED_COUNT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Clock with a period of 8 ns.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #(LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

   // Reset state of the shadow table.
   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_on[i]    = 1'b0;
         shadow_led[i]   = '0;
         shadow_color[i] = '0;
         shadow_due[i]   = '0;
      end
      for (int i = 0; i < LED_COUNT; i++) begin
         shadow_strip[i] = COLOR_BLACK;
      end
   end

   function automatic void set_strip(logic [LED_SEL_W-1:0] idx, logic [LED_COLOR_W-1:0] color);
      if (idx < LED_COUNT) begin
         shadow_strip[idx] = color;
      end
   endfunction

   // Applies one request word to the shadow table and leaves its result words
   // in step_words.
   function automatic void led_table_step(req_item_type it);
      rsp_word_type w;
      bit           placed;
      step_words.delete();
      w      = '0;
      placed = 1'b0;
      case (it.func)
         FUNC_TICK: begin
            // Scan upward so that a later slot overrides an earlier one.
            for (int i = 0; i < SLOTS; i++) begin
               if (shadow_valid[i] && it.now_t >= shadow_due[i]) begin
                  set_strip(shadow_led[i], shadow_on[i] ?
                            LED_COLOR_W'(shadow_color[i]) + 1'b1 : COLOR_BLACK);
                  shadow_valid[i] = 1'b0;
               end
            end
            for (int i = 0; i < LED_COUNT; i++) begin
               w.kind      = KIND_LED;
               w.led_index = i[LED_SEL_W-1:0];
               w.led_color = shadow_strip[i];
               w.last_word = (i == LED_COUNT - 1);
               step_words.push_back(w);
            end
         end
         FUNC_ADD: begin
            w.kind      = KIND_ADD;
            w.last_word = 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
               if (!placed && !shadow_valid[i]) begin
                  shadow_valid[i] = 1'b1;
                  shadow_on[i]    = it.turn_on;
                  shadow_led[i]   = it.led;
                  shadow_color[i] = it.color;
                  shadow_due[i]   = it.due_t;
                  w.slot_used     = i[SLOT_SEL_W-1:0];
                  placed          = 1'b1;
               end
            end
            w.table_full = !placed;
            step_words.push_back(w);
         end
         FUNC_REMOVE: begin
            // A slot beyond the table is only echoed back.
            if (it.slot < SLOTS) begin
               shadow_valid[it.slot] = 1'b0;
               set_strip(shadow_led[it.slot], COLOR_BLACK);
            end
            w.kind      = KIND_REMOVE;
            w.slot_used = it.slot;
            w.last_word = 1'b1;
            step_words.push_back(w);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic dir_row_type row(logic [FUNC_W-1:0] func, logic [TIME_W-1:0] now_t,
                                       logic [TIME_W-1:0] due_t, logic turn_on,
                                       logic [LED_SEL_W-1:0] led,
                                       logic [COLOR_W-1:0] color,
                                       logic [SLOT_SEL_W-1:0] slot, check_mode_type mode,
                                       logic [KIND_W-1:0] kind,
                                       logic [SLOT_SEL_W-1:0] slot_used,
                                       logic table_full);
      dir_row_type r;
      r.item.func        = func;
      r.item.now_t       = now_t;
      r.item.due_t       = due_t;
      r.item.turn_on     = turn_on;
      r.item.led         = led;
      r.item.color       = color;
      r.item.slot        = slot;
      r.mode             = mode;
      r.typed            = '0;
      r.typed.kind       = kind;
      r.typed.slot_used  = slot_used;
      r.typed.table_full = table_full;
      r.typed.last_word  = 1'b1;
      return r;
   endfunction

   function automatic string word_text(rsp_word_type w);
      return $sformatf("kind=%0d led=%0d color=%0d slot=%0d full=%0d last=%0d",
                       w.kind, w.led_index, w.led_color, w.slot_used, w.table_full,
                       w.last_word);
   endfunction

   // Offers one word on the req channel, then records what it must produce.
   task automatic apply_item(input req_item_type it, input check_mode_type mode,
                             input rsp_word_type typed);
      rsp_word_type w;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.func;
      req_tdata  <= {{(REQ_TDATA_W-REQ_USED_W){1'b0}}, it.slot, it.color, it.led,
                     it.turn_on, it.due_t, it.now_t};
      do @(posedge clock); while (req_tready !== 1'b1);
      items_sent++;
      if (it.func == FUNC_TICK) begin
         ticks_sent++;
      end
      led_table_step(it);
      case (mode)
         CHECK_PREDICTED: begin
            foreach (step_words[i]) begin
               pending_words.push_back(step_words[i]);
            end
         end
         CHECK_BLANK_TICK: begin
            for (int i = 0; i < LED_COUNT; i++) begin
               w           = '0;
               w.kind      = KIND_LED;
               w.led_index = i[LED_SEL_W-1:0];
               w.led_color = COLOR_BLACK;
               w.last_word = (i == LED_COUNT - 1);
               pending_words.push_back(w);
            end
         end
         CHECK_STATUS: begin
            pending_words.push_back(typed);
         end
         default: begin
         end
      endcase
   endtask

   // Receiver readiness, redrawn every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Every accepted result word is matched against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got_word.kind       = rsp_tuser;
         got_word.led_index  = rsp_tdata[2:0];
         got_word.led_color  = rsp_tdata[5:3];
         got_word.slot_used  = rsp_tdata[8:6];
         got_word.table_full = rsp_tdata[9];
         got_word.last_word  = rsp_tlast;
         if (pending_words.size() == 0) begin
            $display("%0t: result word with nothing expected: %s", $time,
                     word_text(got_word));
            errors++;
         end else begin
            want_word = pending_words.pop_front();
            checked++;
            if (want_word.table_full) begin
               full_seen++;
            end
            if (got_word !== want_word) begin
               $display("%0t: mismatch, expected %s", $time, word_text(want_word));
               $display("%0t:           actual   %s", $time, word_text(got_word));
               errors++;
            end
         end
      end
   end

   initial begin : stimulus
      req_item_type it;
      int           counted;
      int           pick;

      // Directed words: blank strip after reset, removes of free and
      // out-of-table slots, an ignored function, a full table, override order
      // within a tick and both ends of the time range.
      directed.push_back(row(FUNC_TICK,   32'd0, 32'd0, 1'b0, 3'd0, 2'd0, 3'd0,
                             CHECK_BLANK_TICK, KIND_LED, 3'd0, 1'b0));
      directed.push_back(row(FUNC_REMOVE, 32'd0, 32'd0, 1'b0, 3'd0, 2'd0, 3'd0,
                             CHECK_STATUS, KIND_REMOVE, 3'd0, 1'b0));
      directed.push_back(row(FUNC_REMOVE, 32'd0, 32'd0, 1'b0, 3'd0, 2'd0, 3'd7,
                             CHECK_STATUS, KIND_REMOVE, 3'd7, 1'b0));
      directed.push_back(row(FUNC_UNUSED, 32'd0, 32'd0, 1'b0, 3'd0, 2'd0, 3'd0,
                             CHECK_SILENT, KIND_LED, 3'd0, 1'b0));
      directed.push_back(row(FUNC_ADD,    32'd0, 32'd0, 1'b1, 3'd0, 2'd0, 3'd0,
                             CHECK_STATUS, KIND_ADD, 3'd0, 1'b0));
      directed.push_back(row(FUNC_ADD,    32'd0, 32'hFFFF_FFFF, 1'b1, 3'd7, 2'd3, 3'd0,
                             CHECK_STATUS, KIND_ADD, 3'd1, 1'b0));
      directed.push_back(row(FUNC_ADD,    32'd0, 32'd5, 1'b0, 3'd3, 2'd2, 3'd0,
                             CHECK_STATUS, KIND_ADD, 3'd2, 1'b0));
      directed.push_back(row(FUNC_ADD,    32'd0, 32'd5, 1'b1, 3'd3, 2'd1, 3'd0,
                             CHECK_STATUS, KIND_ADD, 3'd3, 1'b0));
      directed.push_back(row(FUNC_ADD,    32'd0, 32'd10, 1'b1, 3'd5, 2'd2, 3'd0,
                             CHECK_STATUS, KIND_ADD, 3'd4, 1'b0));
      directed.push_back(row(FUNC_ADD,    32'd0, 32'd0, 1'b1, 3'd0, 2'd3, 3'd0,
                             CHECK_STATUS, KIND_ADD, 3'd5, 1'b0));
      directed.push_back(row(FUNC_ADD,    32'd0, 32'd100, 1'b1, 3'd6, 2'd1, 3'd0,
                             CHECK_STATUS, KIND_ADD, 3'd6, 1'b0));
      directed.push_back(row(FUNC_ADD,    32'd0, 32'd1, 1'b1, 3'd1, 2'd1, 3'd0,
                             CHECK_STATUS, KIND_ADD, 3'd0, 1'b1));
      directed.push_back(row(FUNC_TICK,   32'd5, 32'd0, 1'b0, 3'd0, 2'd0, 3'd0,
                             CHECK_PREDICTED, KIND_LED, 3'd0, 1'b0));
      directed.push_back(row(FUNC_TICK,   32'hFFFF_FFFF, 32'd0, 1'b0, 3'd0, 2'd0, 3'd0,
                             CHECK_PREDICTED, KIND_LED, 3'd0, 1'b0));
      directed.push_back(row(FUNC_ADD,    32'd0, 32'd0, 1'b1, 3'd2, 2'd2, 3'd0,
                             CHECK_PREDICTED, KIND_LED, 3'd0, 1'b0));
      directed.push_back(row(FUNC_TICK,   32'd0, 32'd0, 1'b0, 3'd0, 2'd0, 3'd0,
                             CHECK_PREDICTED, KIND_LED, 3'd0, 1'b0));
      directed.push_back(row(FUNC_ADD,    32'd0, 32'd0, 1'b1, 3'd2, 2'd1, 3'd0,
                             CHECK_PREDICTED, KIND_LED, 3'd0, 1'b0));
      directed.push_back(row(FUNC_REMOVE, 32'd0, 32'd0, 1'b0, 3'd0, 2'd0, 3'd0,
                             CHECK_PREDICTED, KIND_LED, 3'd0, 1'b0));
      directed.push_back(row(FUNC_ADD,    32'd0, 32'hFFFF_FFFF, 1'b1, 3'd4, 2'd3, 3'd0,
                             CHECK_PREDICTED, KIND_LED, 3'd0, 1'b0));
      directed.push_back(row(FUNC_TICK,   32'hFFFF_FFFE, 32'd0, 1'b0, 3'd0, 2'd0, 3'd0,
                             CHECK_PREDICTED, KIND_LED, 3'd0, 1'b0));
      directed.push_back(row(FUNC_REMOVE, 32'd0, 32'd0, 1'b0, 3'd0, 2'd0, 3'd6,
                             CHECK_PREDICTED, KIND_LED, 3'd0, 1'b0));
      directed.push_back(row(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 3'd7, 2'd3,
                             3'd7, CHECK_SILENT, KIND_LED, 3'd0, 1'b0));
      directed.push_back(row(FUNC_TICK,   32'hA5A5_5A5A, 32'h5A5A_A5A5, 1'b1, 3'd7, 2'd3,
                             3'd7, CHECK_PREDICTED, KIND_LED, 3'd0, 1'b0));

      wall_now = $urandom_range(0, 1000);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         apply_item(directed[i].item, directed[i].mode, directed[i].typed);
      end

      // Random traffic: mostly adds and ticks that follow a slowly advancing
      // time, so slots fill, fire and get removed; some words use raw values.
      counted = 0;
      while (counted < ITEMS) begin
         if (counted >= 2*ITEMS/3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else if (counted >= ITEMS/3) begin
            tx_idle_pct = 75;
            rx_idle_pct = 11;
         end
         it.now_t   = $urandom();
         it.due_t   = $urandom();
         it.turn_on = $urandom_range(0, 1);
         it.led     = $urandom_range(0, 7);
         it.color   = $urandom_range(0, 3);
         it.slot    = $urandom_range(0, 7);
         pick       = $urandom_range(0, 99);
         if (pick < 25) begin
            it.func = FUNC_TICK;
            if ($urandom_range(0, 15) != 0) begin
               wall_now = wall_now + $urandom_range(0, 4);
               it.now_t = wall_now;
            end
         end else if (pick < 65) begin
            it.func = FUNC_ADD;
            if ($urandom_range(0, 15) != 0) begin
               it.due_t = wall_now + $urandom_range(0, 8);
            end
         end else if (pick < 92) begin
            it.func = FUNC_REMOVE;
         end else begin
            it.func = FUNC_UNUSED;
         end
         apply_item(it, CHECK_PREDICTED, '0);
         counted++;
      end
      req_tvalid <= 1'b0;

      // Drain the remaining results, then give the block time to misbehave.
      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request words (%0d ticks), checked %0d result words,",
               items_sent, ticks_sent, checked);
      $display("of which %0d reported a full table; %0d errors.", full_seen, errors);
      if (errors == 0 && pending_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/tlet_pkg.sv
rtl/core/tlet_ram.sv
rtl/core/tlet_ctrl.sv
rtl/core/tlet_dp.sv
rtl/core/timed_led_event_table.sv
sim/timed_led_event_table_tb.sv
